>>> src/rsn_pkg.sv
// ----------------------------------------------------------------------------
// rsn_pkg
// Shared types and widths for the reflection surface normal pipeline.
// ----------------------------------------------------------------------------
package rsn_pkg;

  localparam int RAY_W  = 32;  // input ray component width
  localparam int COMP_W = 33;  // signed component into a scaling unit
  localparam int MAG_W  = 32;  // component magnitude, at most 2^31
  localparam int SH_W   = 5;   // normalizing shift, 0..30
  localparam int SQ_W   = 64;  // square and sum of squares
  localparam int ROOT_W = 32;  // integer square root of a 64-bit sum
  localparam int UNIT_F = 30;  // fraction bits of the unit rays
  localparam int NRM_W  = 16;  // output normal width

  typedef logic signed [COMP_W-1:0] comp_t;

  // control that travels with every request through a unit
  typedef struct packed {
    logic vld;  // stage holds a request
    logic ok;   // request yields a valid normal so far
  } ctl_t;

endpackage

>>> src/reflection_surface_normal.sv
// ----------------------------------------------------------------------------
// reflection_surface_normal
// Half-vector surface normal from a camera ray and a reflected ray.
// ----------------------------------------------------------------------------
// One pixel request enters per clock while pixel_stall is low, and one normal
// leaves per request, in order. Every scaling pass holds two bit-per-stage
// units: a 32-stage restoring square root and an (F+1)-stage restoring
// divider, with F = 30 for the two ray passes, which run side by side, and
// F = OUT_FRAC_BITS for the final normal pass. The whole pipeline advances
// together and holds only while a finished normal waits at the output under
// result_stall, so pixel_stall follows result_stall and the output register.
// Masked pixels, all-zero rays, rays equal to the (-1,-1,-1) sentinel and
// equal unit rays flow through like any other request and leave as a zero
// normal with normal_valid low.
// ----------------------------------------------------------------------------
module reflection_surface_normal import rsn_pkg::*; #(
  parameter int IN_FRAC_BITS  = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pixel_valid,
  output logic                    pixel_stall,
  input  logic                    pixel_mask,
  input  logic signed [RAY_W-1:0] ray_x,
  input  logic signed [RAY_W-1:0] ray_y,
  input  logic signed [RAY_W-1:0] ray_z,
  input  logic signed [RAY_W-1:0] refl_x,
  input  logic signed [RAY_W-1:0] refl_y,
  input  logic signed [RAY_W-1:0] refl_z,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [NRM_W-1:0] normal_x,
  output logic signed [NRM_W-1:0] normal_y,
  output logic signed [NRM_W-1:0] normal_z,
  output logic                    normal_valid
);

  localparam logic [RAY_W-1:0] SENTINEL = RAY_W'(-(longint'(1) << IN_FRAC_BITS));

  logic adv;

  // input register
  logic             in_vld;
  logic             in_mask;
  logic [RAY_W-1:0] in_ray  [3];
  logic [RAY_W-1:0] in_refl [3];
  logic             ray_ok;
  logic             refl_ok;
  ctl_t             in_ctl;
  comp_t            ray_c  [3];
  comp_t            refl_c [3];

  // ray scaling outputs
  ctl_t                     ur_ctl;
  ctl_t                     uf_ctl;
  logic signed [UNIT_F+1:0] ur [3];
  logic signed [UNIT_F+1:0] uf [3];

  // difference register
  logic  df_vld;
  logic  df_ok;
  comp_t df [3];
  ctl_t  df_ctl;

  // normal scaling output
  ctl_t                            nm_ctl;
  logic signed [OUT_FRAC_BITS+1:0] nm [3];

  // advance everything unless a finished normal is held at the output
  assign adv         = !(result_valid && result_stall);
  assign pixel_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (adv) begin
      in_vld <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_mask    <= pixel_mask;
      in_ray[0]  <= ray_x;
      in_ray[1]  <= ray_y;
      in_ray[2]  <= ray_z;
      in_refl[0] <= refl_x;
      in_refl[1] <= refl_y;
      in_refl[2] <= refl_z;
    end
  end

  // zero and sentinel rays, like masked pixels, give no normal
  always_comb begin
    ray_ok  = (in_ray[0] != '0) || (in_ray[1] != '0) || (in_ray[2] != '0);
    ray_ok  = ray_ok && !((in_ray[0] == SENTINEL) && (in_ray[1] == SENTINEL)
                          && (in_ray[2] == SENTINEL));
    refl_ok = (in_refl[0] != '0) || (in_refl[1] != '0) || (in_refl[2] != '0);
    refl_ok = refl_ok && !((in_refl[0] == SENTINEL) && (in_refl[1] == SENTINEL)
                           && (in_refl[2] == SENTINEL));
    in_ctl.vld = in_vld;
    in_ctl.ok  = in_mask && ray_ok && refl_ok;
    for (int i = 0; i < 3; i++) begin
      ray_c[i]  = {in_ray[i][RAY_W-1], in_ray[i]};
      refl_c[i] = {in_refl[i][RAY_W-1], in_refl[i]};
    end
  end

  rsn_unit #(.F(UNIT_F)) u_ray (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .ctl_in  (in_ctl),
    .c       (ray_c),
    .ctl_out (ur_ctl),
    .q       (ur)
  );

  rsn_unit #(.F(UNIT_F)) u_refl (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .ctl_in  (in_ctl),
    .c       (refl_c),
    .ctl_out (uf_ctl),
    .q       (uf)
  );

  // reflected unit ray minus camera unit ray
  always_ff @(posedge clk) begin
    if (rst) begin
      df_vld <= 1'b0;
    end else if (adv) begin
      df_vld <= ur_ctl.vld && uf_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      df_ok <= ur_ctl.ok && uf_ctl.ok;
      for (int i = 0; i < 3; i++) begin
        df[i] <= COMP_W'(uf[i]) - COMP_W'(ur[i]);
      end
    end
  end

  // equal unit rays give no normal
  always_comb begin
    df_ctl.vld = df_vld;
    df_ctl.ok  = df_ok && ((df[0] != '0) || (df[1] != '0) || (df[2] != '0));
  end

  rsn_unit #(.F(OUT_FRAC_BITS)) u_nrm (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .ctl_in  (df_ctl),
    .c       (df),
    .ctl_out (nm_ctl),
    .q       (nm)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= nm_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      normal_valid <= nm_ctl.ok;
      normal_x     <= nm_ctl.ok ? NRM_W'(nm[0]) : '0;
      normal_y     <= nm_ctl.ok ? NRM_W'(nm[1]) : '0;
      normal_z     <= nm_ctl.ok ? NRM_W'(nm[2]) : '0;
    end
  end

endmodule

>>> src/rsn_unit.sv
// ----------------------------------------------------------------------------
// rsn_unit
// Pipelined scaling of a 3-vector to unit length, rounded to nearest.
// ----------------------------------------------------------------------------
module rsn_unit import rsn_pkg::*; #(
  parameter int F = 30
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  ctl_t                ctl_in,
  input  comp_t               c [3],
  output ctl_t                ctl_out,
  output logic signed [F+1:0] q [3]
);

  localparam int QW = F + 1;

  // stage 1: magnitudes and signs
  ctl_t             s1_ctl;
  logic [MAG_W-1:0] s1_a [3];
  logic [2:0]       s1_neg;
  // stage 2: largest magnitude
  ctl_t             s2_ctl;
  logic [MAG_W-1:0] s2_a [3];
  logic [MAG_W-1:0] s2_m;
  logic [2:0]       s2_neg;
  logic [MAG_W-1:0] m_next;
  // stage 3: normalizing shift
  ctl_t             s3_ctl;
  logic [MAG_W-1:0] s3_a [3];
  logic [SH_W-1:0]  s3_sh;
  logic [2:0]       s3_neg;
  logic [SH_W-1:0]  sh_next;
  logic [SH_W-1:0]  msb;
  // stage 4: shifted magnitudes
  ctl_t             s4_ctl;
  logic [MAG_W-1:0] s4_a [3];
  logic [2:0]       s4_neg;
  // stage 5: squares
  ctl_t             s5_ctl;
  logic [MAG_W-1:0] s5_a [3];
  logic [SQ_W-1:0]  s5_sq [3];
  logic [2:0]       s5_neg;
  // square root stages, index 0 holds the sum
  ctl_t              sq_ctl  [0:ROOT_W];
  logic [SQ_W-1:0]   sq_rem  [0:ROOT_W];
  logic [ROOT_W-1:0] sq_root [0:ROOT_W];
  logic [MAG_W-1:0]  sq_a    [0:ROOT_W][3];
  logic [2:0]        sq_neg  [0:ROOT_W];
  // division stages, index 0 holds the rounded numerators
  ctl_t              dv_ctl [0:QW];
  logic [SQ_W-1:0]   dv_rem [0:QW][3];
  logic [QW-1:0]     dv_q   [0:QW][3];
  logic [ROOT_W-1:0] dv_n   [0:QW];
  logic [2:0]        dv_neg [0:QW];

  always_comb begin
    m_next = s1_a[0];
    if (s1_a[1] > m_next) begin
      m_next = s1_a[1];
    end
    if (s1_a[2] > m_next) begin
      m_next = s1_a[2];
    end
  end

  always_comb begin
    msb = '0;
    for (int i = 0; i < MAG_W - 2; i++) begin
      if (s2_m[i]) begin
        msb = SH_W'(i);
      end
    end
    if (s2_m[MAG_W-1] || s2_m[MAG_W-2]) begin
      sh_next = '0;
    end else begin
      sh_next = SH_W'(MAG_W - 2) - msb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl    <= '0;
      s2_ctl    <= '0;
      s3_ctl    <= '0;
      s4_ctl    <= '0;
      s5_ctl    <= '0;
      sq_ctl[0] <= '0;
    end else if (adv) begin
      s1_ctl    <= ctl_in;
      s2_ctl    <= s1_ctl;
      s3_ctl    <= s2_ctl;
      s4_ctl    <= s3_ctl;
      s5_ctl    <= s4_ctl;
      sq_ctl[0] <= s5_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_a[i] <= c[i][COMP_W-1] ? MAG_W'(-c[i]) : MAG_W'(c[i]);
        s1_neg[i] <= c[i][COMP_W-1];
        s2_a[i] <= s1_a[i];
        s3_a[i] <= s2_a[i];
        s4_a[i] <= s3_a[i] << s3_sh;
        s5_a[i] <= s4_a[i];
        s5_sq[i] <= SQ_W'(s4_a[i]) * SQ_W'(s4_a[i]);
        sq_a[0][i] <= s5_a[i];
      end
      s2_m       <= m_next;
      s2_neg     <= s1_neg;
      s3_sh      <= sh_next;
      s3_neg     <= s2_neg;
      s4_neg     <= s3_neg;
      s5_neg     <= s4_neg;
      sq_rem[0]  <= s5_sq[0] + s5_sq[1] + s5_sq[2];
      sq_root[0] <= '0;
      sq_neg[0]  <= s5_neg;
    end
  end

  // restoring square root, one result bit per stage
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - j;
    logic [SQ_W+1:0] trial;
    logic            take;

    assign trial = ((SQ_W+2)'(sq_root[j]) << (K + 1)) | ((SQ_W+2)'(1) << (2 * K));
    assign take  = (SQ_W+2)'(sq_rem[j]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_ctl[j+1] <= '0;
      end else if (adv) begin
        sq_ctl[j+1] <= sq_ctl[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[j+1]  <= take ? sq_rem[j] - trial[SQ_W-1:0] : sq_rem[j];
        sq_root[j+1] <= take ? sq_root[j] | (ROOT_W'(1) << K) : sq_root[j];
        sq_a[j+1]    <= sq_a[j];
        sq_neg[j+1]  <= sq_neg[j];
      end
    end
  end

  // numerators with half the divisor added for rounding
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_ctl[0] <= '0;
    end else if (adv) begin
      dv_ctl[0] <= sq_ctl[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (SQ_W'(sq_a[ROOT_W][i]) << F) + SQ_W'(sq_root[ROOT_W] >> 1);
        dv_q[0][i]   <= '0;
      end
      dv_n[0]   <= sq_root[ROOT_W];
      dv_neg[0] <= sq_neg[ROOT_W];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = QW - 1 - j;
    logic [SQ_W-1:0] dsh;

    assign dsh = SQ_W'(dv_n[j]) << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_ctl[j+1] <= '0;
      end else if (adv) begin
        dv_ctl[j+1] <= dv_ctl[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_rem[j][i] >= dsh) begin
            dv_rem[j+1][i] <= dv_rem[j][i] - dsh;
            dv_q[j+1][i]   <= dv_q[j][i] | (QW'(1) << K);
          end else begin
            dv_rem[j+1][i] <= dv_rem[j][i];
            dv_q[j+1][i]   <= dv_q[j][i];
          end
        end
        dv_n[j+1]   <= dv_n[j];
        dv_neg[j+1] <= dv_neg[j];
      end
    end
  end

  // apply signs
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= dv_ctl[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        q[i] <= dv_neg[QW][i] ? -$signed({1'b0, dv_q[QW][i]}) : $signed({1'b0, dv_q[QW][i]});
      end
    end
  end

endmodule

>>> verif/tb_reflection_surface_normal.sv
// ----------------------------------------------------------------------------
// tb_reflection_surface_normal
// Self-checking bench for the half-vector surface normal pipeline. Drives
// directed corner pixels, then random pixels, predicts each normal in the
// bench and compares every result field by field in order.
// ----------------------------------------------------------------------------
module tb_reflection_surface_normal;
  import rsn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_FB  = 16;
  localparam int OUT_FB = 14;
  localparam int LAT    = 115 + OUT_FB;

  typedef struct {
    logic [15:0] nx, ny, nz;
    logic        nv;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  logic pixel_mask = 1'b0;
  logic signed [RAY_W-1:0] ray_x = '0, ray_y = '0, ray_z = '0;
  logic signed [RAY_W-1:0] refl_x = '0, refl_y = '0, refl_z = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;
  logic normal_valid;

  normal_t pending_normals[$];
  int  mismatches = 0;
  bit  quiet = 1'b0;  // no idling on either side in the last part of the run

  reflection_surface_normal #(.IN_FRAC_BITS(IN_FB), .OUT_FRAC_BITS(OUT_FB)) dut (.*);

  // 2 ns period
  initial begin
    forever #1 clk = ~clk;
  end

  // Limit: well above the slowest legal run with bursts on both sides
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scale a vector to unit length with fb fraction bits, rounding to nearest.
  function automatic void scale_unit(input longint c[3], input int fb, output longint o[3]);
    logic [63:0] a[3];
    logic [63:0] m, s, n, q;
    m = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = (c[i] < 0) ? -c[i] : c[i];
      if (a[i] > m) m = a[i];
    end
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) a[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) s += a[i] * a[i];
    n = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << fb) + (n >> 1)) / n;
      o[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic bit ray_usable(longint c[3]);
    longint sent;
    sent = -(longint'(1) << IN_FB);
    if (c[0] == 0 && c[1] == 0 && c[2] == 0) return 1'b0;
    if (c[0] == sent && c[1] == sent && c[2] == sent) return 1'b0;
    return 1'b1;
  endfunction

  function automatic normal_t predict_normal(logic mask, logic signed [31:0] r[3],
                                             logic signed [31:0] f[3]);
    normal_t res;
    longint cr[3], cf[3], ur[3], uf[3], d[3], nr[3];
    res = '{16'd0, 16'd0, 16'd0, 1'b0};
    for (int i = 0; i < 3; i++) begin
      cr[i] = r[i];
      cf[i] = f[i];
    end
    if (!mask || !ray_usable(cr) || !ray_usable(cf)) return res;
    scale_unit(cr, 30, ur);
    scale_unit(cf, 30, uf);
    for (int i = 0; i < 3; i++) d[i] = uf[i] - ur[i];
    if (d[0] == 0 && d[1] == 0 && d[2] == 0) return res;
    scale_unit(d, OUT_FB, nr);
    res.nx = nr[0][15:0];
    res.ny = nr[1][15:0];
    res.nz = nr[2][15:0];
    res.nv = 1'b1;
    return res;
  endfunction

  // Send one request and hold it until accepted; valid stays high for the
  // next request and drops only for an idle burst or a pause.
  task automatic send_pixel(logic mask, logic signed [31:0] r[3], logic signed [31:0] f[3]);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_mask  <= mask;
    ray_x  <= r[0]; ray_y  <= r[1]; ray_z  <= r[2];
    refl_x <= f[0]; refl_y <= f[1]; refl_z <= f[2];
    do @(posedge clk); while (pixel_stall);
    pending_normals.insert(pending_normals.size(), predict_normal(mask, r, f));
    @(negedge clk);
  endtask

  // Receiver stall in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      result_stall <= 1'b0;
    end
  end

  // Check each accepted result against the oldest prediction
  initial begin
    normal_t exp_n;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (pending_normals.size() == 0) begin
          $display("%0t: unexpected result nx=%0d", $time, normal_x);
          mismatches++;
        end else begin
          exp_n = pending_normals.pop_front();
          if (normal_x !== exp_n.nx || normal_y !== exp_n.ny ||
              normal_z !== exp_n.nz || normal_valid !== exp_n.nv) begin
            $display("%0t: expected (%0d,%0d,%0d,%0b) actual (%0d,%0d,%0d,%0b)", $time,
                     $signed(exp_n.nx), $signed(exp_n.ny), $signed(exp_n.nz), exp_n.nv,
                     normal_x, normal_y, normal_z, normal_valid);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2 ** 20)) - (1 <<< 19);
      2: return ($urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff);
      default: return $signed($urandom_range(0, 600)) - 300;
    endcase
  endfunction

  task automatic test_corners();
    logic signed [31:0] one, sent, mn, mx;
    one = 1 <<< IN_FB;
    sent = -one;
    mn = 32'sh8000_0000;
    mx = 32'sh7fff_ffff;
    send_pixel(1'b0, '{one, 0, 0}, '{0, one, 0});                 // masked out
    send_pixel(1'b1, '{0, 0, 0}, '{0, one, 0});                   // zero camera ray
    send_pixel(1'b1, '{one, 0, 0}, '{0, 0, 0});                   // zero reflected ray
    send_pixel(1'b1, '{sent, sent, sent}, '{0, one, 0});          // sentinel camera
    send_pixel(1'b1, '{one, 0, 0}, '{sent, sent, sent});          // sentinel reflected
    send_pixel(1'b1, '{one, 2, 3}, '{one, 2, 3});                 // equal rays
    send_pixel(1'b1, '{one, 0, 0}, '{2 * one, 0, 0});             // same direction
    send_pixel(1'b1, '{0, 0, -one}, '{0, 0, one});                // straight back
    send_pixel(1'b1, '{mn, mn, mn}, '{mx, mx, mx});               // extremes
    send_pixel(1'b1, '{mx, mn, mx}, '{mn, mx, 1});
    send_pixel(1'b1, '{1, 0, 0}, '{0, -1, 0});                    // tiny rays
    send_pixel(1'b1, '{mn, 0, 0}, '{0, mn, 0});
    send_pixel(1'b1, '{sent, sent, 0}, '{-1, -1, -1});            // near sentinel
    send_pixel(1'b1, '{32'shffff_ffff, 32'sh5555_5555, 32'shaaaa_aaaa},
               '{32'sh0f0f_0f0f, 32'shf0f0_f0f0, 32'sh0000_ffff});
  endtask

  task automatic test_random(int count);
    logic signed [31:0] r[3], f[3];
    repeat (count) begin
      foreach (r[i]) begin
        r[i] = rand_comp();
        f[i] = rand_comp();
      end
      case ($urandom_range(0, 19))
        0: f = r;
        1: r = '{-(1 <<< IN_FB), -(1 <<< IN_FB), -(1 <<< IN_FB)};
        2: f = '{0, 0, 0};
        default: ;
      endcase
      send_pixel($urandom_range(0, 9) != 0, r, f);
    end
  endtask

  // Hold off new requests until every expected result has come back
  task automatic test_drain_pause();
    pixel_valid <= 1'b0;
    while (pending_normals.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_corners();
    test_random(300);
    test_drain_pause();
    test_random(250);
    quiet = 1'b1;
    test_random(100);
    pixel_valid <= 1'b0;
    while (pending_normals.size() != 0) @(negedge clk);
    repeat (LAT) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

>>> files.f
src/rsn_pkg.sv
src/rsn_unit.sv
src/reflection_surface_normal.sv
verif/tb_reflection_surface_normal.sv
